// ===== design/byte_plane_rle_span_decoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder assertion macros
// Clocked assertion shorthands used by the decoder top-level RTL.
// ---------------------------------------------------------------------------
`ifndef BYTE_PLANE_RLE_SPAN_DECODER_UNIT_MACROS_SVH
`define BYTE_PLANE_RLE_SPAN_DECODER_UNIT_MACROS_SVH

// Check prop at every rising clk_i edge outside reset.
`define BRPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check prop at every rising clk_i edge, reset included.
`define BRPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/brpd_pkg.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder package
// Shared widths, limits, decode phase and state/result types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package brpd_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxPlanes = 4;

  localparam int unsigned SpanW  = 13;
  localparam int unsigned PlaneW = 3;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgSpanWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneCount = 1'd1;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_VALUE,
    PH_LITERAL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [7:0]        literal_left;
    logic [7:0]        repeat_length;
    logic [SpanW-1:0]  pixel_position;
    logic [PlaneW-1:0] current_plane;
  } state_t;

  typedef struct packed {
    logic [7:0]  run_value;
    logic [11:0] start_pixel;
    logic [7:0]  run_length;
    logic [1:0]  plane_index;
    logic        record_done;
    logic        record_status;
  } result_t;

endpackage

// ===== design/brpd_intf.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder channels
// Valid/ready channels for code words in and decoded run words out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       record_end;

  modport source (output valid, output code_byte, output record_end, input ready);
  modport sink (input valid, input code_byte, input record_end, output ready);
endinterface

interface brpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_value;
  logic [11:0] start_pixel;
  logic [7:0]  run_length;
  logic [1:0]  plane_index;
  logic        record_done;
  logic        record_status;

  modport source (
    output valid, output run_value, output start_pixel, output run_length,
    output plane_index, output record_done, output record_status, input ready
  );
  modport sink (
    input valid, input run_value, input start_pixel, input run_length,
    input plane_index, input record_done, input record_status, output ready
  );
endinterface

// ===== design/brpd_cfg.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder configuration
// Holds span width and plane count, clamped to their legal ranges on write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brpd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [brpd_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic [brpd_pkg::SpanW-1:0]    width_o,
  output logic [brpd_pkg::PlaneW-1:0]   planes_o
);
  import brpd_pkg::*;

  localparam logic [SpanW-1:0]  WidthMax  = SpanW'(MaxWidth);
  localparam logic [PlaneW-1:0] PlanesMax = PlaneW'(MaxPlanes);

  logic [SpanW-1:0]  width_q, width_d;
  logic [PlaneW-1:0] planes_q, planes_d;
  logic [PlaneW-1:0] wr_planes;

  assign wr_planes = cfg_wdata_i[PlaneW-1:0];

  always_comb begin
    width_d  = width_q;
    planes_d = planes_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSpanWidth: begin
          if (cfg_wdata_i == '0) begin
            width_d = SpanW'(1);
          end else if (cfg_wdata_i > WidthMax) begin
            width_d = WidthMax;
          end else begin
            width_d = cfg_wdata_i;
          end
        end
        CfgPlaneCount: begin
          if (wr_planes == '0) begin
            planes_d = PlaneW'(1);
          end else if (wr_planes > PlanesMax) begin
            planes_d = PlanesMax;
          end else begin
            planes_d = wr_planes;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SpanW'(1);
      planes_q <= PlaneW'(1);
    end else begin
      width_q  <= width_d;
      planes_q <= planes_d;
    end
  end

  assign width_o  = width_q;
  assign planes_o = planes_q;

endmodule

// ===== design/brpd_step.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder step
// Decodes one code word against the current state: next state and run word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brpd_step (
  input  brpd_pkg::state_t              state_i,
  input  logic [7:0]                    code_byte_i,
  input  logic                          record_end_i,
  input  logic [brpd_pkg::SpanW-1:0]    width_i,
  input  logic [brpd_pkg::PlaneW-1:0]   planes_i,
  output brpd_pkg::state_t              state_o,
  output logic                          emit_o,
  output brpd_pkg::result_t             result_o
);
  import brpd_pkg::*;

  function automatic state_t next_plane(state_t s, logic [PlaneW-1:0] planes);
    state_t r;
    r                = s;
    r.current_plane  = s.current_plane + PlaneW'(1);
    r.pixel_position = '0;
    r.literal_left   = '0;
    r.repeat_length  = '0;
    r.phase          = (r.current_plane >= planes) ? PH_DONE : PH_COUNT;
    return r;
  endfunction

  state_t           st;
  result_t          res;
  logic             have_run;
  logic             clean;
  logic [SpanW-1:0] room;
  logic [SpanW-1:0] len;

  always_comb begin
    st       = state_i;
    res      = '0;
    have_run = 1'b0;
    room     = '0;
    len      = '0;
    clean    = 1'b0;

    if (st.phase != PH_DONE) begin
      if (st.current_plane >= planes_i) begin
        st.phase = PH_DONE;
      end else if (st.pixel_position >= width_i) begin
        st = next_plane(st, planes_i);
      end
    end

    case (st.phase)
      PH_COUNT: begin
        if (!code_byte_i[7]) begin
          st.repeat_length = {1'b0, code_byte_i[6:0]} + 8'd1;
          st.phase         = PH_VALUE;
        end else begin
          st.literal_left = 8'(9'd256 - {1'b0, code_byte_i});
          st.phase        = PH_LITERAL;
        end
      end
      PH_VALUE: begin
        room = width_i - st.pixel_position;
        len  = ({5'd0, st.repeat_length} < room) ? {5'd0, st.repeat_length} : room;
        have_run            = 1'b1;
        res.run_value       = code_byte_i;
        res.start_pixel     = st.pixel_position[11:0];
        res.run_length      = len[7:0];
        res.plane_index     = st.current_plane[1:0];
        st.pixel_position   = st.pixel_position + len;
        st.repeat_length    = '0;
        st.phase            = PH_COUNT;
        if (st.pixel_position >= width_i) begin
          st = next_plane(st, planes_i);
        end
      end
      PH_LITERAL: begin
        have_run          = 1'b1;
        res.run_value     = code_byte_i;
        res.start_pixel   = st.pixel_position[11:0];
        res.run_length    = 8'd1;
        res.plane_index   = st.current_plane[1:0];
        st.pixel_position = st.pixel_position + SpanW'(1);
        if (st.literal_left != '0) begin
          st.literal_left = st.literal_left - 8'd1;
        end
        if (st.literal_left == '0) begin
          st.phase = PH_COUNT;
        end
        if (st.pixel_position >= width_i) begin
          st = next_plane(st, planes_i);
        end
      end
      default: begin
      end
    endcase

    if (record_end_i) begin
      clean = (st.phase == PH_DONE) ||
              (st.phase == PH_COUNT && st.pixel_position == '0);
      res.record_done   = 1'b1;
      res.record_status = !clean;
      st                = '0;
      st.phase          = PH_COUNT;
    end
  end

  assign state_o  = st;
  assign emit_o   = have_run || record_end_i;
  assign result_o = res;

endmodule

// ===== design/byte_plane_rle_span_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder
// Decodes run-length coded byte planes of a channel record into pixel runs.
//
//   channel   direction  word                          handshake
//   in_i      in         code_byte, record_end         valid/ready
//   out_o     out        run, pixel, plane, status     valid/ready
//   cfg       in         span_width, plane_count       write enable
//
// One code word per cycle while the output is not stalled; a word moves
// from the input register through the decode step into the output register.
// The decode state loop closes through the step and the state register.
// Reset clears state and the valid flags of both registers; configuration
// resets to a span width and plane count of one. A stalled output holds
// the run word and back-pressures the input register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_plane_rle_span_decoder_unit_macros.svh"

module byte_plane_rle_span_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [brpd_pkg::CfgW-1:0]     cfg_wdata_i,
  brpd_in_if.sink                       in_i,
  brpd_out_if.source                    out_o
);
  import brpd_pkg::*;

  logic [SpanW-1:0]  width;
  logic [PlaneW-1:0] planes;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  state_t  state_q, state_d, step_state;
  logic    step_emit;
  result_t step_res;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic out_free;
  logic step_fire;
  logic in_take;

  brpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .width_o     (width),
    .planes_o    (planes)
  );

  brpd_step u_step (
    .state_i      (state_q),
    .code_byte_i  (in_byte_q),
    .record_end_i (in_end_q),
    .width_i      (width),
    .planes_i     (planes),
    .state_o      (step_state),
    .emit_o       (step_emit),
    .result_o     (step_res)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign step_fire = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step_fire;
  assign in_take   = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end

    state_d = step_fire ? step_state : state_q;

    out_valid_d = out_valid_q;
    if (step_fire && step_emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.code_byte;
      in_end_q  <= in_i.record_end;
    end
    if (step_fire && step_emit) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.run_value     = out_q.run_value;
  assign out_o.start_pixel   = out_q.start_pixel;
  assign out_o.run_length    = out_q.run_length;
  assign out_o.plane_index   = out_q.plane_index;
  assign out_o.record_done   = out_q.record_done;
  assign out_o.record_status = out_q.record_status;

  `BRPD_ASSERT(a_status_only_at_end,
    out_valid_q && out_q.record_status |-> out_q.record_done,
    "status without record end")
  `BRPD_ASSERT(a_empty_run_is_end,
    out_valid_q && out_q.run_length == 8'd0 |-> out_q.record_done,
    "empty run word outside record end")
  `BRPD_ASSERT(a_run_length_max,
    out_valid_q |-> out_q.run_length <= 8'd128,
    "run length above 128")
  `BRPD_ASSERT(a_end_clears_state,
    step_fire && in_end_q |=> state_q.pixel_position == '0 &&
      state_q.current_plane == '0 && state_q.phase == PH_COUNT,
    "state not cleared after record end")
  `BRPD_ASSERT_ALWAYS(a_reset_empty,
    !rst_ni |=> !out_valid_q && !in_valid_q,
    "registers hold words in reset")

endmodule

// ===== tb/tb_byte_plane_rle_span_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// Byte plane RLE span decoder testbench
// Feeds code words through the valid/ready input channel and compares
// every decoded run word with a behavioral decoder kept in step with the
// accepted input. A directed table covers extremes, cut runs, clean and
// malformed record ends and register changes inside a record. Random
// phases follow, each with its own span and plane setting and one of
// three mixes of sender and receiver gaps. Most records are well formed;
// the rest are truncated, padded, or random noise.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_byte_plane_rle_span_decoder_unit;
  import brpd_pkg::*;

  localparam int unsigned NumPhases = 12;
  localparam int unsigned PhaseWords = 104;
  localparam int unsigned DirRows = 38;

  typedef enum {ROW_CFG, ROW_WORD, ROW_TYPED} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    logic [7:0]         code;
    logic               last;
    result_t            want;
  } dir_row_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } code_word_t;

  localparam result_t NoRun = '0;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;

  brpd_in_if  in_if ();
  brpd_out_if out_if ();

  byte_plane_rle_span_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Decoder copy: registers and record state
  logic [CfgW-1:0]   span_cfg;
  logic [PlaneW-1:0] plane_cfg;
  phase_e            dec_phase;
  logic [7:0]        lit_left;
  logic [7:0]        rep_len;
  logic [SpanW-1:0]  pix_pos;
  logic [PlaneW-1:0] cur_plane;

  result_t     pending_runs[$];
  code_word_t  code_stream[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 200;

  int unsigned span_plan[NumPhases]  = '{1, 0, 6, 4096, 3, 17, 8191, 2, 130, 5, 4, 40};
  int unsigned plane_plan[NumPhases] = '{1, 0, 4, 2, 3, 7, 1, 4, 2, 5, 3, 4};

  dir_row_t dir_table[DirRows] = '{
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'hFF, 1'b1,
      result_t'({8'hFF, 12'd0, 8'd1, 2'd0, 1'b1, 1'b0})},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h05, 1'b1,
      result_t'({8'h00, 12'd0, 8'd0, 2'd0, 1'b1, 1'b1})},
    '{ROW_CFG,   CfgSpanWidth,  13'd4096, 8'h00, 1'b0, NoRun},
    '{ROW_CFG,   CfgPlaneCount, 13'd4,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h7F, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h00, 1'b0,
      result_t'({8'h00, 12'd0, 8'd128, 2'd0, 1'b0, 1'b0})},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h80, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h01, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h81, 1'b1, NoRun},
    '{ROW_CFG,   CfgSpanWidth,  13'd3,    8'h00, 1'b0, NoRun},
    '{ROW_CFG,   CfgPlaneCount, 13'd2,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'hFC, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'hA5, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h5A, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'hC3, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h01, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h55, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h66, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h12, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h34, 1'b1,
      result_t'({8'h00, 12'd0, 8'd0, 2'd0, 1'b1, 1'b0})},
    '{ROW_CFG,   CfgSpanWidth,  13'd8191, 8'h00, 1'b0, NoRun},
    '{ROW_CFG,   CfgPlaneCount, 13'd7,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h03, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h09, 1'b0, NoRun},
    '{ROW_CFG,   CfgSpanWidth,  13'd2,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h0A, 1'b0, NoRun},
    '{ROW_CFG,   CfgPlaneCount, 13'd1,    8'h00, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h77, 1'b1,
      result_t'({8'h00, 12'd0, 8'd0, 2'd0, 1'b1, 1'b0})},
    '{ROW_CFG,   CfgSpanWidth,  13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_CFG,   CfgPlaneCount, 13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h00, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h00, 1'b1,
      result_t'({8'h00, 12'd0, 8'd1, 2'd0, 1'b1, 1'b0})},
    '{ROW_CFG,   CfgPlaneCount, 13'd2,    8'h00, 1'b0, NoRun},
    '{ROW_WORD,  CfgSpanWidth,  13'd0,    8'h7F, 1'b0, NoRun},
    '{ROW_TYPED, CfgSpanWidth,  13'd0,    8'h22, 1'b1,
      result_t'({8'h22, 12'd0, 8'd1, 2'd0, 1'b1, 1'b0})}
  };

  always #6 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic void clear_record();
    dec_phase = PH_COUNT;
    lit_left  = '0;
    rep_len   = '0;
    pix_pos   = '0;
    cur_plane = '0;
  endfunction

  function automatic void advance_plane(input int unsigned np);
    cur_plane = cur_plane + 3'd1;
    pix_pos   = '0;
    lit_left  = '0;
    rep_len   = '0;
    dec_phase = (cur_plane >= np) ? PH_DONE : PH_COUNT;
  endfunction

  // Decode one code word; returns 1 when it yields a run word
  function automatic bit decode_word(input logic [7:0] code, input logic last,
                                     output result_t run);
    int unsigned w;
    int unsigned np;
    int unsigned room;
    int unsigned len;
    bit has_run;
    w  = (span_cfg == 0) ? 1 : ((span_cfg > MaxWidth) ? MaxWidth : span_cfg);
    np = (plane_cfg == 0) ? 1 : ((plane_cfg > MaxPlanes) ? MaxPlanes : plane_cfg);
    run = '0;
    has_run = 1'b0;
    if (dec_phase != PH_DONE) begin
      if (cur_plane >= np) dec_phase = PH_DONE;
      else if (pix_pos >= w) advance_plane(np);
    end
    case (dec_phase)
      PH_COUNT: begin
        if (code < 8'd128) begin
          rep_len   = code + 8'd1;
          dec_phase = PH_VALUE;
        end else begin
          lit_left  = 8'(9'd256 - {1'b0, code});
          dec_phase = PH_LITERAL;
        end
      end
      PH_VALUE: begin
        room = w - pix_pos;
        len  = (rep_len < room) ? rep_len : room;
        has_run = 1'b1;
        run.run_value   = code;
        run.start_pixel = pix_pos[11:0];
        run.run_length  = 8'(len);
        run.plane_index = cur_plane[1:0];
        pix_pos   = pix_pos + SpanW'(len);
        rep_len   = '0;
        dec_phase = PH_COUNT;
        if (pix_pos >= w) advance_plane(np);
      end
      PH_LITERAL: begin
        has_run = 1'b1;
        run.run_value   = code;
        run.start_pixel = pix_pos[11:0];
        run.run_length  = 8'd1;
        run.plane_index = cur_plane[1:0];
        pix_pos = pix_pos + SpanW'(1);
        if (lit_left != 0) lit_left = lit_left - 8'd1;
        if (lit_left == 0) dec_phase = PH_COUNT;
        if (pix_pos >= w) advance_plane(np);
      end
      default: ;
    endcase
    if (last) begin
      run.record_done   = 1'b1;
      run.record_status = !((dec_phase == PH_DONE) ||
                            (dec_phase == PH_COUNT && pix_pos == 0));
      clear_record();
      has_run = 1'b1;
    end
    return has_run;
  endfunction

  task automatic send_word(input logic [7:0] code, input logic last,
                           input bit typed, input result_t typed_run);
    result_t run;
    bit has_run;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.code_byte  <= code;
    in_if.record_end <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    has_run = decode_word(code, last, run);
    @(negedge clk_i);
    if (typed) pending_runs = {pending_runs, typed_run};
    else if (has_run) pending_runs = {pending_runs, run};
  endtask

  // Hold input, drain every expected run, then let the pipeline settle
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (pending_runs.size() != 0 && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSpanWidth) span_cfg = val;
    else plane_cfg = val[PlaneW-1:0];
    @(negedge clk_i);
  endtask

  task automatic build_phase(input int unsigned w, input int unsigned np,
                             input int unsigned target);
    code_word_t rec[$];
    int unsigned kind;
    int unsigned pos;
    int unsigned room;
    int unsigned lim;
    int unsigned n;
    int unsigned cut;
    code_stream.delete();
    while (code_stream.size() < target) begin
      rec.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          rec = {rec, code_word_t'{8'($urandom), 1'($urandom_range(0, 4) == 0)}};
      end else begin
        for (int p = 0; p < np && rec.size() < target; p++) begin
          pos = 0;
          while (pos < w && rec.size() < target) begin
            room = w - pos;
            lim  = (room > 128 || $urandom_range(0, 3) == 0) ? 128 : room;
            n    = $urandom_range(1, lim);
            if ($urandom_range(0, 1) == 1) begin
              rec = {rec, code_word_t'{8'(n - 1), 1'b0}};
              rec = {rec, code_word_t'{8'($urandom), 1'b0}};
            end else begin
              rec = {rec, code_word_t'{8'(256 - n), 1'b0}};
              repeat ((n < room) ? n : room)
                rec = {rec, code_word_t'{8'($urandom), 1'b0}};
            end
            pos += (n < room) ? n : room;
          end
        end
        if (kind == 1)
          repeat ($urandom_range(1, 3)) rec = {rec, code_word_t'{8'($urandom), 1'b0}};
        if (kind == 2 && rec.size() > 1) begin
          cut = $urandom_range(1, rec.size() - 1);
          rec = rec[0:cut-1];
        end
        rec[rec.size()-1].last = 1'b1;
      end
      code_stream = {code_stream, rec};
    end
    code_stream = code_stream[0:target-1];
  endtask

  always @(negedge clk_i) begin
    if (long_hold_req && hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_runs
    result_t got;
    result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = {out_if.run_value, out_if.start_pixel, out_if.run_length,
             out_if.plane_index, out_if.record_done, out_if.record_status};
      if (pending_runs.size() == 0) begin
        flag_mismatch($sformatf("unexpected run word %h", got));
      end else begin
        want = pending_runs.pop_front();
        if (got.run_value !== want.run_value)
          flag_mismatch($sformatf("run_value %h, want %h", got.run_value, want.run_value));
        if (got.start_pixel !== want.start_pixel)
          flag_mismatch($sformatf("start_pixel %0d, want %0d", got.start_pixel,
                                  want.start_pixel));
        if (got.run_length !== want.run_length)
          flag_mismatch($sformatf("run_length %0d, want %0d", got.run_length,
                                  want.run_length));
        if (got.plane_index !== want.plane_index)
          flag_mismatch($sformatf("plane_index %0d, want %0d", got.plane_index,
                                  want.plane_index));
        if (got.record_done !== want.record_done)
          flag_mismatch($sformatf("record_done %b, want %b", got.record_done,
                                  want.record_done));
        if (got.record_status !== want.record_status)
          flag_mismatch($sformatf("record_status %b, want %b", got.record_status,
                                  want.record_status));
      end
    end
  end

  initial begin
    #(64'd5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned w;
    int unsigned np;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CfgSpanWidth;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.code_byte  = '0;
    in_if.record_end = 1'b0;
    out_if.ready     = 1'b0;
    span_cfg  = 13'd1;
    plane_cfg = 3'd1;
    clear_record();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      end else begin
        send_word(dir_table[i].code, dir_table[i].last,
                  dir_table[i].kind == ROW_TYPED, dir_table[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 4) ? 37 : ((ph < 8) ? 83 : 0);
      recv_idle_pct = (ph < 4) ? 83 : ((ph < 8) ? 37 : 0);
      write_reg(CfgSpanWidth, CfgW'(span_plan[ph]));
      write_reg(CfgPlaneCount, CfgW'(plane_plan[ph]));
      // starve the output for a while so the block backs up
      if (ph == 8) long_hold_req = 1'b1;
      w  = (span_plan[ph] == 0) ? 1 : ((span_plan[ph] > MaxWidth) ? MaxWidth : span_plan[ph]);
      np = (plane_plan[ph] == 0) ? 1 :
           ((plane_plan[ph] > MaxPlanes) ? MaxPlanes : plane_plan[ph]);
      build_phase(w, np, PhaseWords);
      foreach (code_stream[k]) send_word(code_stream[k].code, code_stream[k].last, 1'b0, NoRun);
    end

    wait_idle();
    if (pending_runs.size() != 0)
      flag_mismatch($sformatf("%0d run words never arrived", pending_runs.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
